[hdl/prslz_pkg.sv]
// ----------------------------------------------------------------------------
// prslz_pkg
// Types and constants shared by the PRS LZ decompressor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prslz_pkg;

  localparam int unsigned DistW = 14;
  localparam int unsigned LenW  = 9;

  localparam logic [DistW-1:0] LONG_OFS_BASE  = 14'd8192;
  localparam logic [DistW-1:0] SHORT_OFS_BASE = 14'd256;
  localparam logic [LenW-1:0]  LEN_BIAS       = 9'd2;
  localparam logic [2:0]       LEN_MASK       = 3'd7;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_END    = 2'd1,
    ST_BADREF = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_FLAG_A    = 4'd0,
    PH_FLAG_B    = 4'd1,
    PH_SHORT_B1  = 4'd2,
    PH_SHORT_B0  = 4'd3,
    PH_LIT       = 4'd4,
    PH_LONG_LO   = 4'd5,
    PH_LONG_HI   = 4'd6,
    PH_LONG_EXT  = 4'd7,
    PH_SHORT_OFF = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_CHECK  = 3'd2,
    S_RD     = 3'd3,
    S_WR     = 3'd4,
    S_MID    = 3'd5,
    S_FLAGS  = 3'd6,
    S_TAIL   = 3'd7
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic             push_from_ram;
    logic [7:0]       lit_byte;
    logic             rd_en;
    logic [DistW-1:0] back_dist;
    logic             emit_data;
    logic             emit_status;
    status_e          status_code;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic lanes_full;
    logic lanes_empty;
    logic dist_bad;
  } stat_t;

endpackage

`default_nettype wire

[hdl/prs_lz_decompressor.sv]
// A literal's result becomes valid after its transfer and after the flags consumed after it,
// provided the output register is free.
// A new input byte is taken only once the last one is through; a byte that starts a copy
// of L bytes adds a check, then a read, write and lane step per byte, no step at the end.
// Reset clears all parse state at once; the history needs no clearing pass.
// ----------------------------------------------------------------------------
// prs_lz_decompressor
// Byte-serial PRS LZ77 decompressor with packed, multi-byte result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_lz_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 8192,
  parameter int unsigned OUT_LANES    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // in_byte
  input  wire logic        s_axis_tlast_i,   // stream_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // out_byte0..3, byte_count, zero pad
  output logic [1:0]       m_axis_tuser_o,   // status
  output logic             m_axis_tlast_o    // run_last
);
  import prslz_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  prslz_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_byte_i  (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .s_tready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  prslz_dpath #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .OUT_LANES   (OUT_LANES)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_tready_i(m_axis_tready_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o),
    .m_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[hdl/prslz_ram.sv]
// ----------------------------------------------------------------------------
// prslz_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prslz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/prslz_dpath.sv]
// ----------------------------------------------------------------------------
// prslz_dpath
// History window, write pointer, lane packing buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prslz_dpath #(
  parameter int unsigned WINDOW_DEPTH = 8192,
  parameter int unsigned OUT_LANES    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire prslz_pkg::cmd_t  cmd_i,
  output prslz_pkg::stat_t      stat_o,
  input  wire logic             m_tready_i,
  output logic                  m_tvalid_o,
  output logic [39:0]           m_tdata_o,
  output logic [1:0]            m_tuser_o,
  output logic                  m_tlast_o
);
  import prslz_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned PW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

  logic [AW-1:0]      wp_q, wp_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [3:0][7:0]    lane_q, lane_d;
  logic [2:0]         lane_cnt_q, lane_cnt_d;
  logic               oval_q, oval_d;
  logic [3:0][7:0]    obytes_q, obytes_d;
  logic [2:0]         ocnt_q, ocnt_d;
  logic [1:0]         ostat_q, ostat_d;
  logic               olast_q, olast_d;

  logic [7:0]  push_byte;
  logic [7:0]  ram_rdata;
  logic [14:0] idx_sum, idx_wrap;
  logic        out_free;

  assign idx_sum  = 15'(wp_q) + 15'(WINDOW_DEPTH) - 15'(cmd_i.back_dist);
  assign idx_wrap = (idx_sum >= 15'(WINDOW_DEPTH)) ? idx_sum - 15'(WINDOW_DEPTH) : idx_sum;

  prslz_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(wp_q),
    .wdata_i(push_byte),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_wrap[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign push_byte = cmd_i.push_from_ram ? ram_rdata : cmd_i.lit_byte;
  assign out_free  = !oval_q || m_tready_i;

  assign stat_o.out_free    = out_free;
  assign stat_o.lanes_full  = (lane_cnt_q == 3'(LANES));
  assign stat_o.lanes_empty = (lane_cnt_q == 3'd0);
  assign stat_o.dist_bad    = (cmd_i.back_dist == '0) || (cmd_i.back_dist > DistW'(prod_q));

  always_comb begin
    wp_d       = wp_q;
    prod_d     = prod_q;
    lane_d     = lane_q;
    lane_cnt_d = lane_cnt_q;
    oval_d     = oval_q;
    obytes_d   = obytes_q;
    ocnt_d     = ocnt_q;
    ostat_d    = ostat_q;
    olast_d    = olast_q;

    if (oval_q && m_tready_i) begin
      oval_d = 1'b0;
    end

    if (cmd_i.push) begin
      lane_d[lane_cnt_q[1:0]] = push_byte;
      lane_cnt_d = lane_cnt_q + 3'd1;
      wp_d = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (prod_q < PW'(WINDOW_DEPTH)) begin
        prod_d = prod_q + PW'(1);
      end
    end

    if (cmd_i.emit_data) begin
      oval_d     = 1'b1;
      obytes_d   = lane_q;
      ocnt_d     = lane_cnt_q;
      ostat_d    = ST_DATA;
      olast_d    = cmd_i.emit_last;
      lane_d     = '0;
      lane_cnt_d = 3'd0;
    end else if (cmd_i.emit_status) begin
      oval_d   = 1'b1;
      obytes_d = '0;
      ocnt_d   = 3'd0;
      ostat_d  = cmd_i.status_code;
      olast_d  = 1'b1;
    end

    if (cmd_i.clear) begin
      wp_d       = '0;
      prod_d     = '0;
      lane_d     = '0;
      lane_cnt_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      prod_q     <= '0;
      lane_q     <= '0;
      lane_cnt_q <= 3'd0;
      oval_q     <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      prod_q     <= prod_d;
      lane_q     <= lane_d;
      lane_cnt_q <= lane_cnt_d;
      oval_q     <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obytes_q <= obytes_d;
    ocnt_q   <= ocnt_d;
    ostat_q  <= ostat_d;
    olast_q  <= olast_d;
  end

  assign m_tvalid_o = oval_q;
  assign m_tdata_o  = {5'd0, ocnt_q, obytes_q};
  assign m_tuser_o  = ostat_q;
  assign m_tlast_o  = olast_q;

endmodule

`default_nettype wire

[hdl/prslz_ctrl.sv]
// ----------------------------------------------------------------------------
// prslz_ctrl
// Token parser and sequencer: flag handling, copy loop and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module prslz_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic [7:0]       s_byte_i,
  input  wire logic             s_last_i,
  output logic                  s_tready_o,
  input  wire prslz_pkg::stat_t stat_i,
  output prslz_pkg::cmd_t       cmd_o
);
  import prslz_pkg::*;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [3:0]       bits_q, bits_d;
  logic [15:0]      word_q, word_d;
  logic [1:0]       slen_q, slen_d;
  logic             halted_q, halted_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [DistW-1:0] dist_q, dist_d;
  status_e          status_q, status_d;

  logic [15:0] word_full;
  logic        finish;

  assign word_full = {byte_q, word_q[7:0]};

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ctrl_d   = ctrl_q;
    bits_d   = bits_q;
    word_d   = word_q;
    slen_d   = slen_q;
    halted_d = halted_q;
    byte_d   = byte_q;
    last_d   = last_q;
    len_d    = len_q;
    dist_d   = dist_q;
    status_d = status_q;
    finish   = 1'b0;
    s_tready_o = 1'b0;

    cmd_o               = '0;
    cmd_o.lit_byte      = byte_q;
    cmd_o.back_dist     = dist_q;
    cmd_o.status_code   = status_q;

    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          byte_d  = s_byte_i;
          last_d  = s_last_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (halted_q) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_FLAGS;
          case (phase_q) inside
            PH_FLAG_A, PH_FLAG_B, PH_SHORT_B1, PH_SHORT_B0: begin
              ctrl_d = byte_q;
              bits_d = 4'd8;
            end
            PH_LIT: begin
              cmd_o.push = 1'b1;
              phase_d    = PH_FLAG_A;
            end
            PH_LONG_LO: begin
              word_d  = {8'd0, byte_q};
              phase_d = PH_LONG_HI;
            end
            PH_LONG_HI: begin
              word_d  = word_full;
              phase_d = PH_FLAG_A;
              if (word_full == 16'd0) begin
                status_d = ST_END;
                halted_d = 1'b1;
                state_d  = S_TAIL;
              end else if ((word_full[2:0] & LEN_MASK) == 3'd0) begin
                phase_d = PH_LONG_EXT;
              end else begin
                len_d   = LenW'(word_full[2:0]) + LEN_BIAS;
                dist_d  = LONG_OFS_BASE - DistW'(word_full[15:3]);
                state_d = S_CHECK;
              end
            end
            PH_LONG_EXT: begin
              phase_d = PH_FLAG_A;
              len_d   = LenW'(byte_q) + LenW'(1);
              dist_d  = LONG_OFS_BASE - DistW'(word_q[15:3]);
              state_d = S_CHECK;
            end
            PH_SHORT_OFF: begin
              phase_d = PH_FLAG_A;
              len_d   = LenW'(slen_q) + LEN_BIAS;
              dist_d  = SHORT_OFS_BASE - DistW'(byte_q);
              state_d = S_CHECK;
            end
            default: begin
              phase_d = PH_FLAG_A;
            end
          endcase
        end
      end

      S_CHECK: begin
        if (stat_i.dist_bad) begin
          status_d = ST_BADREF;
          halted_d = 1'b1;
          state_d  = S_TAIL;
        end else begin
          state_d = S_RD;
        end
      end

      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_WR;
      end

      S_WR: begin
        cmd_o.push          = 1'b1;
        cmd_o.push_from_ram = 1'b1;
        len_d = len_q - LenW'(1);
        state_d = (len_q == LenW'(1)) ? S_FLAGS : S_MID;
      end

      S_MID: begin
        // A full lane group is sent on before the copy goes on.
        if (!stat_i.lanes_full) begin
          state_d = S_RD;
        end else if (stat_i.out_free) begin
          cmd_o.emit_data = 1'b1;
          state_d         = S_RD;
        end
      end

      S_FLAGS: begin
        if (!halted_q && (phase_q < PH_LIT) && (bits_q != 4'd0)) begin
          ctrl_d = {1'b0, ctrl_q[7:1]};
          bits_d = bits_q - 4'd1;
          unique case (phase_q)
            PH_FLAG_A:   phase_d = ctrl_q[0] ? PH_LIT : PH_FLAG_B;
            PH_FLAG_B:   phase_d = ctrl_q[0] ? PH_LONG_LO : PH_SHORT_B1;
            PH_SHORT_B1: begin
              slen_d  = {ctrl_q[0], 1'b0};
              phase_d = PH_SHORT_B0;
            end
            default: begin
              slen_d  = {slen_q[1], ctrl_q[0]};
              phase_d = PH_SHORT_OFF;
            end
          endcase
        end else begin
          state_d = S_TAIL;
        end
      end

      S_TAIL: begin
        if (status_q != ST_DATA) begin
          if (stat_i.out_free) begin
            cmd_o.emit_status = 1'b1;
            finish = 1'b1;
          end
        end else if (!stat_i.lanes_empty) begin
          if (stat_i.out_free) begin
            cmd_o.emit_data = 1'b1;
            cmd_o.emit_last = 1'b1;
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
        if (finish) begin
          status_d = ST_DATA;
          state_d  = S_IDLE;
          if (last_q) begin
            cmd_o.clear = 1'b1;
            phase_d  = PH_FLAG_A;
            ctrl_d   = 8'd0;
            bits_d   = 4'd0;
            word_d   = 16'd0;
            slen_d   = 2'd0;
            halted_d = 1'b0;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_FLAG_A;
      ctrl_q   <= 8'd0;
      bits_q   <= 4'd0;
      word_q   <= 16'd0;
      slen_q   <= 2'd0;
      halted_q <= 1'b0;
      status_q <= ST_DATA;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ctrl_q   <= ctrl_d;
      bits_q   <= bits_d;
      word_q   <= word_d;
      slen_q   <= slen_d;
      halted_q <= halted_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    len_q  <= len_d;
    dist_q <= dist_d;
  end

endmodule

`default_nettype wire

[hdl/prslz_checker.sv]
// ----------------------------------------------------------------------------
// prslz_checker
// Port-level checks on the decompressor's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module prslz_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);
  import prslz_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_DATA) |->
      (m_axis_tdata_o[34:32] == 3'd0) && m_axis_tlast_o)
    else $error("status transfer carries data or is not last");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[34:32] <= 3'd4) && (m_axis_tuser_o <= ST_BADREF))
    else $error("bad byte count or status code");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_DATA) |-> (m_axis_tdata_o[34:32] != 3'd0))
    else $error("empty data transfer");

endmodule

bind prs_lz_decompressor prslz_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

`default_nettype wire
